// ===== src/assert_macros.svh =====
// assertion macros used by the core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/aled_pkg.sv =====
// package with widths, codes and defaults of the addressable led duty encoder
`default_nettype none
package aled_pkg;
	localparam int NUM_LEDS_DEF = 64;
	localparam int COLOR_W = 24;
	localparam int LEVEL_W = 8;
	localparam int DUTY_W = 16;
	localparam int SLOT_W = 8;
	localparam int IDX_W = 7;
	localparam int BIT_W = 5;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		CMD_WRITE_PIXEL = 2'd0,
		CMD_FILL = 2'd1,
		CMD_START = 2'd2,
		CMD_TICK = 2'd3
	} cmd_t;

	localparam logic [1:0] CHAN_GREEN = 2'd0;
	localparam logic [1:0] CHAN_RED = 2'd1;
	localparam logic [1:0] CHAN_BLUE = 2'd2;

	localparam logic [1:0] REG_ONE_DUTY = 2'd0;
	localparam logic [1:0] REG_ZERO_DUTY = 2'd1;
	localparam logic [1:0] REG_RESET_SLOTS = 2'd2;

	localparam logic [DUTY_W-1:0] ONE_DUTY_RST = 16'd60;
	localparam logic [DUTY_W-1:0] ZERO_DUTY_RST = 16'd30;
	localparam logic [SLOT_W-1:0] RESET_SLOTS_RST = 8'd64;
	localparam logic [BIT_W-1:0] LAST_BIT = 5'd23;
endpackage
`default_nettype wire

// ===== src/aled_if.sv =====
// channel interfaces for command items and duty results
`default_nettype none
interface aled_item_if
	import aled_pkg::*;
;
	logic valid;
	logic ready;
	logic [1:0] cmd;
	logic [IDX_W-1:0] led_index;
	logic [LEVEL_W-1:0] red;
	logic [LEVEL_W-1:0] green;
	logic [LEVEL_W-1:0] blue;
	logic [IDX_W-1:0] fill_count;
	logic [1:0] fill_channel;
	logic [LEVEL_W-1:0] intensity;

	modport source (output valid, cmd, led_index, red, green, blue, fill_count,
		fill_channel, intensity, input ready);
	modport sink (input valid, cmd, led_index, red, green, blue, fill_count,
		fill_channel, intensity, output ready);
endinterface

interface aled_result_if
	import aled_pkg::*;
;
	logic valid;
	logic ready;
	logic [DUTY_W-1:0] duty;
	logic last;

	modport source (output valid, duty, last, input ready);
	modport sink (input valid, duty, last, output ready);
endinterface
`default_nettype wire

// ===== src/aled_store.sv =====
// color memory, one write port and one registered read port
`default_nettype none
module aled_store
	import aled_pkg::*;
#(
	parameter int NUM_LEDS = NUM_LEDS_DEF,
	parameter int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [COLOR_W-1:0] wdata,
	input wire logic [AW-1:0] raddr,
	output logic [COLOR_W-1:0] rdata
);
	logic [COLOR_W-1:0] mem [NUM_LEDS];
	logic [COLOR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ===== src/addressable_led_duty_encoder_core.sv =====
// addressable led duty encoder: command sequencer, register port and duty output
// write pixel and start take effect when accepted; a tick goes through read, then emit,
// which waits for a free output register; a fill sweeps one led per cycle over all leds
// ready is low while a fill or tick is in progress; the sequencer state sets this
// reset (arst_n low) blanks every led, stops the frame and loads register defaults
// results wait in an output register while new items are taken
`default_nettype none
module addressable_led_duty_encoder_core
	import aled_pkg::*;
#(
	parameter int NUM_LEDS = NUM_LEDS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [PADDR_W-1:0] paddr,
	input wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic pready,
	aled_item_if.sink item,
	aled_result_if.source result
);
	`include "assert_macros.svh"

	localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam logic [AW-1:0] LAST_LED = AW'(NUM_LEDS - 1);
	localparam logic [IDX_W-1:0] NUM_LEDS_IDX = IDX_W'(NUM_LEDS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_FILL = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [DUTY_W-1:0] one_duty_q;
	logic [DUTY_W-1:0] zero_duty_q;
	logic [SLOT_W-1:0] reset_slots_q;
	logic [NUM_LEDS-1:0] blank_q;
	logic frame_active_q;
	logic [SLOT_W-1:0] rsc_q;
	logic [AW-1:0] led_pos_q;
	logic [BIT_W-1:0] bit_pos_q;
	logic [AW-1:0] fill_k_q;
	logic [IDX_W-1:0] fill_count_q;
	logic [COLOR_W-1:0] fill_color_q;
	logic out_valid_q;
	logic [DUTY_W-1:0] duty_q;
	logic last_q;

	logic accept;
	logic cfg_write;
	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic [COLOR_W-1:0] mem_wdata;
	logic [COLOR_W-1:0] mem_rdata;
	logic fill_hit;
	logic in_reset_slots;
	logic is_last;
	logic emit_load;
	logic [DUTY_W-1:0] duty_d;
	logic [COLOR_W-1:0] fill_color_d;
	logic fill_ok;
	logic pixel_ok;

	assign accept = item.valid && item.ready;
	assign item.ready = (state_q == ST_IDLE);
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[3:2])
			REG_ONE_DUTY: prdata = {{(PDATA_W-DUTY_W){1'b0}}, one_duty_q};
			REG_ZERO_DUTY: prdata = {{(PDATA_W-DUTY_W){1'b0}}, zero_duty_q};
			REG_RESET_SLOTS: prdata = {{(PDATA_W-SLOT_W){1'b0}}, reset_slots_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_duty_q <= ONE_DUTY_RST;
			zero_duty_q <= ZERO_DUTY_RST;
			reset_slots_q <= RESET_SLOTS_RST;
		end else if (cfg_write) begin
			unique case (paddr[3:2])
				REG_ONE_DUTY: one_duty_q <= pwdata[DUTY_W-1:0];
				REG_ZERO_DUTY: zero_duty_q <= pwdata[DUTY_W-1:0];
				REG_RESET_SLOTS: reset_slots_q <= pwdata[SLOT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (item.fill_channel)
			CHAN_GREEN: fill_color_d = {item.intensity, 16'd0};
			CHAN_RED: fill_color_d = {8'd0, item.intensity, 8'd0};
			default: fill_color_d = {16'd0, item.intensity};
		endcase
	end

	assign fill_ok = (item.fill_count <= NUM_LEDS_IDX) && (item.fill_channel <= CHAN_BLUE);
	assign pixel_ok = (item.led_index < NUM_LEDS_IDX);
	assign fill_hit = (IDX_W'(fill_k_q) < fill_count_q);

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = fill_k_q;
		mem_wdata = fill_color_q;
		if (state_q == ST_FILL) begin
			mem_we = fill_hit;
		end else if (accept && item.cmd == CMD_WRITE_PIXEL && pixel_ok) begin
			mem_we = 1'b1;
			mem_waddr = item.led_index[AW-1:0];
			mem_wdata = {item.green, item.red, item.blue};
		end
	end

	aled_store #(
		.NUM_LEDS(NUM_LEDS),
		.AW(AW)
	) u_store (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(led_pos_q),
		.rdata(mem_rdata)
	);

	// bit select and duty pick for the current slot
	assign in_reset_slots = (rsc_q < reset_slots_q);
	assign is_last = !in_reset_slots && (led_pos_q == LAST_LED) && (bit_pos_q == LAST_BIT);
	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || result.ready);

	always_comb begin
		if (in_reset_slots || blank_q[led_pos_q]) begin
			duty_d = '0;
		end else if (mem_rdata[LAST_BIT - bit_pos_q]) begin
			duty_d = one_duty_q;
		end else begin
			duty_d = zero_duty_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			blank_q <= '1;
			frame_active_q <= 1'b0;
			rsc_q <= '0;
			led_pos_q <= '0;
			bit_pos_q <= '0;
			fill_k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (item.cmd)
							CMD_WRITE_PIXEL: begin
								if (pixel_ok) begin
									blank_q[item.led_index[AW-1:0]] <= 1'b0;
								end
							end
							CMD_FILL: begin
								if (fill_ok) begin
									fill_k_q <= '0;
									state_q <= ST_FILL;
								end
							end
							CMD_START: begin
								if (!frame_active_q) begin
									frame_active_q <= 1'b1;
									rsc_q <= '0;
									led_pos_q <= '0;
									bit_pos_q <= '0;
								end
							end
							CMD_TICK: begin
								if (frame_active_q) begin
									state_q <= ST_READ;
								end
							end
							default: ;
						endcase
					end
				end
				ST_FILL: begin
					blank_q[fill_k_q] <= !fill_hit;
					fill_k_q <= fill_k_q + 1'b1;
					if (fill_k_q == LAST_LED) begin
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_load) begin
						state_q <= ST_IDLE;
						if (in_reset_slots) begin
							rsc_q <= rsc_q + 1'b1;
						end else if (is_last) begin
							frame_active_q <= 1'b0;
							led_pos_q <= '0;
							bit_pos_q <= '0;
							rsc_q <= '0;
						end else if (bit_pos_q == LAST_BIT) begin
							bit_pos_q <= '0;
							led_pos_q <= led_pos_q + 1'b1;
						end else begin
							bit_pos_q <= bit_pos_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && item.cmd == CMD_FILL) begin
			fill_count_q <= item.fill_count;
			fill_color_q <= fill_color_d;
		end
		if (emit_load) begin
			duty_q <= duty_d;
			last_q <= is_last;
		end
	end

	assign result.valid = out_valid_q;
	assign result.duty = duty_q;
	assign result.last = last_q;

	`ASSERT_NEXT(a_last_ends_frame, emit_load && is_last, !frame_active_q,
		"frame still active after last code")
	`ASSERT_IMP(a_idle_positions, !frame_active_q,
		rsc_q == '0 && led_pos_q == '0 && bit_pos_q == '0,
		"frame positions not cleared outside a frame")
	`ASSERT_NEXT(a_emit_waits, state_q == ST_EMIT && out_valid_q && !result.ready,
		state_q == ST_EMIT && out_valid_q,
		"pending result overwritten")
endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// testbench for the addressable led duty encoder: commands driven, duty codes checked
module tb;
	import aled_pkg::*;

	localparam int N_LEDS = NUM_LEDS_DEF;
	localparam int SETTLE = N_LEDS + 16;
	localparam int LIMIT = 500000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS = 110;
	localparam logic [1:0] CHAN_NONE = 2'd3;

	typedef struct {
		cmd_t cmd;
		logic [IDX_W-1:0] led_index;
		logic [LEVEL_W-1:0] red;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] blue;
		logic [IDX_W-1:0] fill_count;
		logic [1:0] fill_channel;
		logic [LEVEL_W-1:0] intensity;
	} led_cmd_t;

	typedef struct {
		logic [DUTY_W-1:0] duty;
		logic last;
	} duty_code_t;

	class duty_scoreboard;
		bit [COLOR_W-1:0] colors [N_LEDS];
		bit blank [N_LEDS];
		bit running;
		bit [SLOT_W-1:0] slots_sent;
		bit [5:0] led_pos;
		bit [BIT_W-1:0] bit_pos;
		bit [DUTY_W-1:0] one_duty;
		bit [DUTY_W-1:0] zero_duty;
		bit [SLOT_W-1:0] slot_cfg;
		duty_code_t pending [$];
		int errors;

		function new();
			for (int k = 0; k < N_LEDS; k++) begin
				colors[k] = '0;
				blank[k] = 1'b1;
			end
			running = 1'b0;
			slots_sent = '0;
			led_pos = '0;
			bit_pos = '0;
			one_duty = ONE_DUTY_RST;
			zero_duty = ZERO_DUTY_RST;
			slot_cfg = RESET_SLOTS_RST;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] ridx, logic [PDATA_W-1:0] value);
			case (ridx)
				REG_ONE_DUTY: one_duty = value[DUTY_W-1:0];
				REG_ZERO_DUTY: zero_duty = value[DUTY_W-1:0];
				REG_RESET_SLOTS: slot_cfg = value[SLOT_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_item(led_cmd_t it);
			duty_code_t code;
			case (it.cmd)
				CMD_WRITE_PIXEL: begin
					if (it.led_index < N_LEDS) begin
						colors[it.led_index[5:0]] = {it.green, it.red, it.blue};
						blank[it.led_index[5:0]] = 1'b0;
					end
				end
				CMD_FILL: begin
					if (it.fill_count <= N_LEDS && it.fill_channel <= CHAN_BLUE) begin
						for (int k = 0; k < N_LEDS; k++) begin
							if (k < it.fill_count) begin
								case (it.fill_channel)
									CHAN_GREEN: colors[k] = {it.intensity, 16'h0};
									CHAN_RED: colors[k] = {8'h0, it.intensity, 8'h0};
									default: colors[k] = {16'h0, it.intensity};
								endcase
								blank[k] = 1'b0;
							end else begin
								blank[k] = 1'b1;
							end
						end
					end
				end
				CMD_START: begin
					if (!running) begin
						running = 1'b1;
						slots_sent = '0;
						led_pos = '0;
						bit_pos = '0;
					end
				end
				default: begin
					if (running) begin
						if (slots_sent < slot_cfg) begin
							slots_sent++;
							code.duty = '0;
							code.last = 1'b0;
						end else begin
							code.duty = '0;
							if (!blank[led_pos])
								code.duty = colors[led_pos][LAST_BIT - bit_pos] ? one_duty : zero_duty;
							code.last = (led_pos == N_LEDS - 1) && (bit_pos == LAST_BIT);
							if (code.last) begin
								running = 1'b0;
								led_pos = '0;
								bit_pos = '0;
								slots_sent = '0;
							end else if (bit_pos == LAST_BIT) begin
								bit_pos = '0;
								led_pos++;
							end else begin
								bit_pos++;
							end
						end
						pending.push_back(code);
					end
				end
			endcase
		endfunction

		function void check_result(logic [DUTY_W-1:0] duty, logic last);
			duty_code_t code;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected duty code: duty %0d last %0b", duty, last);
				return;
			end
			code = pending.pop_front();
			if (duty !== code.duty || last !== code.last) begin
				errors++;
				if (errors <= 10)
					$display("duty code mismatch: expected duty %0d last %0b, got duty %0d last %0b",
						code.duty, code.last, duty, last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	aled_item_if item_ch ();
	aled_result_if result_ch ();

	duty_scoreboard sb = new();
	bit idle_on = 1'b0;
	int stall_left = 0;
	int unsigned cycles = 0;

	addressable_led_duty_encoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item(item_ch),
		.result(result_ch)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			sb.check_result(result_ch.duty, result_ch.last);
	end

	always @(negedge clk) begin
		if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 3);
		if (stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	function automatic led_cmd_t mk_cmd(cmd_t c, int idx, int g, int r, int b, int cnt,
		int ch, int lvl);
		led_cmd_t it;
		it.cmd = c;
		it.led_index = IDX_W'(idx);
		it.green = LEVEL_W'(g);
		it.red = LEVEL_W'(r);
		it.blue = LEVEL_W'(b);
		it.fill_count = IDX_W'(cnt);
		it.fill_channel = 2'(ch);
		it.intensity = LEVEL_W'(lvl);
		return it;
	endfunction

	// mostly in-range indexes, counts and channels, some out of range
	function automatic led_cmd_t random_cmd(cmd_t c);
		led_cmd_t it;
		it.cmd = c;
		if ($urandom_range(0, 7) == 0)
			it.led_index = IDX_W'($urandom_range(N_LEDS, 127));
		else
			it.led_index = IDX_W'($urandom_range(0, N_LEDS - 1));
		it.red = LEVEL_W'($urandom);
		it.green = LEVEL_W'($urandom);
		it.blue = LEVEL_W'($urandom);
		if ($urandom_range(0, 7) == 0)
			it.fill_count = IDX_W'($urandom_range(N_LEDS + 1, 127));
		else
			it.fill_count = IDX_W'($urandom_range(0, N_LEDS));
		if ($urandom_range(0, 9) == 0)
			it.fill_channel = CHAN_NONE;
		else
			it.fill_channel = 2'($urandom_range(0, 2));
		it.intensity = LEVEL_W'($urandom);
		return it;
	endfunction

	function automatic cmd_t pick_cmd(int tick_w, int write_w, int start_w, int fill_w);
		int r;
		r = $urandom_range(0, tick_w + write_w + start_w + fill_w - 1);
		if (r < tick_w)
			return CMD_TICK;
		if (r < tick_w + write_w)
			return CMD_WRITE_PIXEL;
		if (r < tick_w + write_w + start_w)
			return CMD_START;
		return CMD_FILL;
	endfunction

	task automatic send_item(led_cmd_t it);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.cmd <= it.cmd;
		item_ch.led_index <= it.led_index;
		item_ch.red <= it.red;
		item_ch.green <= it.green;
		item_ch.blue <= it.blue;
		item_ch.fill_count <= it.fill_count;
		item_ch.fill_channel <= it.fill_channel;
		item_ch.intensity <= it.intensity;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_item(it);
		@(negedge clk);
	endtask

	task automatic apb_write(logic [1:0] ridx, logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {ridx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(ridx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(logic [DUTY_W-1:0] one_d, logic [DUTY_W-1:0] zero_d,
		logic [SLOT_W-1:0] slots);
		apb_write(REG_ONE_DUTY, PDATA_W'(one_d));
		apb_write(REG_ZERO_DUTY, PDATA_W'(zero_d));
		apb_write(REG_RESET_SLOTS, PDATA_W'(slots));
	endtask

	task automatic wait_results();
		if (sb.pending.size() != 0) begin
			item_ch.valid <= 1'b0;
			while (sb.pending.size() != 0) @(negedge clk);
		end
	endtask

	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_ch.valid = 1'b0;
		item_ch.cmd = CMD_WRITE_PIXEL;
		item_ch.led_index = '0;
		item_ch.red = '0;
		item_ch.green = '0;
		item_ch.blue = '0;
		item_ch.fill_count = '0;
		item_ch.fill_channel = '0;
		item_ch.intensity = '0;
		result_ch.ready = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_config(ONE_DUTY_RST, ZERO_DUTY_RST, 8'd2);
		idle_on = 1'b1;
		send_item(mk_cmd(CMD_TICK, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk_cmd(CMD_WRITE_PIXEL, 0, 8'hff, 8'h00, 8'h81, 0, 0, 0));
		send_item(mk_cmd(CMD_WRITE_PIXEL, N_LEDS - 1, 8'hff, 8'hff, 8'hff, 0, 0, 0));
		send_item(mk_cmd(CMD_WRITE_PIXEL, N_LEDS, 8'h55, 8'h55, 8'h55, 0, 0, 0));
		send_item(mk_cmd(CMD_WRITE_PIXEL, 127, 8'haa, 8'haa, 8'haa, 0, 0, 0));
		send_item(mk_cmd(CMD_FILL, 0, 0, 0, 0, N_LEDS + 1, CHAN_GREEN, 8'hff));
		send_item(mk_cmd(CMD_FILL, 0, 0, 0, 0, 127, CHAN_RED, 8'hff));
		send_item(mk_cmd(CMD_FILL, 0, 0, 0, 0, 3, CHAN_NONE, 8'hff));
		send_item(mk_cmd(CMD_START, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk_cmd(CMD_START, 0, 0, 0, 0, 0, 0, 0));
		repeat (8) send_item(mk_cmd(CMD_TICK, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk_cmd(CMD_FILL, 0, 0, 0, 0, N_LEDS, CHAN_BLUE, 8'hff));
		repeat (3) send_item(mk_cmd(CMD_TICK, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk_cmd(CMD_FILL, 0, 0, 0, 0, 0, CHAN_RED, 8'h7f));
		repeat (2) send_item(mk_cmd(CMD_TICK, 0, 0, 0, 0, 0, 0, 0));
		wait_idle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: set_config(16'h0000, 16'h0000, 8'h00);
				1: set_config(16'hffff, 16'hffff, 8'hff);
				2: set_config(16'hffff, 16'h0000, 8'h01);
				3: set_config(16'h0000, 16'hffff, 8'hff);
				default: set_config(DUTY_W'($urandom), DUTY_W'($urandom),
					SLOT_W'($urandom_range(0, 40)));
			endcase
			idle_on = (p < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
			repeat (PHASE_ITEMS) begin
				send_item(random_cmd(pick_cmd(65, 18, 10, 7)));
				if ($urandom_range(0, 49) == 0)
					wait_results();
			end
			wait_idle();
		end

		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+src
src/aled_pkg.sv
src/aled_if.sv
src/aled_store.sv
src/addressable_led_duty_encoder_core.sv
test/tb.sv
